@@ sv/lcdns_pkg.sv @@
package lcdns_pkg;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_INIT  = 1'b1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int HOLD_W     = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_PULSE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NIBBLE_SETTLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_SETTLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_WAIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POWERUP_WAIT   = 3'd4;

  localparam logic [7:0]  RST_ENABLE_PULSE   = 8'd2;
  localparam logic [7:0]  RST_NIBBLE_SETTLE  = 8'd5;
  localparam logic [9:0]  RST_COMMAND_SETTLE = 10'd50;
  localparam logic [15:0] RST_CLEAR_WAIT     = 16'd2000;
  localparam logic [17:0] RST_POWERUP_WAIT   = 18'd100000;

  localparam logic [7:0] BYTE_CLEAR  = 8'h01;
  localparam logic [3:0] NIBBLE_WAKE = 4'h3;

  localparam int INIT_STEPS = 27;
  localparam int BYTE_STEPS = 4;
  localparam int INIT_LEAD  = 3;
  localparam int STEP_W     = $clog2(INIT_STEPS);
  localparam int ROM_IDX_W  = STEP_W - 2;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } seq_state_t;

  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic       clear;
    logic [7:0] byte_value;
  } job_t;

  typedef struct packed {
    logic [7:0]  enable_pulse_us;
    logic [7:0]  nibble_settle_us;
    logic [9:0]  command_settle_us;
    logic [15:0] clear_wait_us;
    logic [17:0] powerup_wait_us;
  } cfg_t;

  function automatic logic [7:0] init_rom(input logic [ROM_IDX_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'h28;
      3'd1: b = 8'h28;
      3'd2: b = 8'h08;
      3'd3: b = 8'h01;
      3'd4: b = 8'h06;
      3'd5: b = 8'h0E;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ sv/lcdns_cfg.sv @@
module lcdns_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lcdns_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcdns_pkg::CFG_DATA_W-1:0] cfg_data,
  output lcdns_pkg::cfg_t                cfg
);
  import lcdns_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable_pulse_us   <= RST_ENABLE_PULSE;
      cfg.nibble_settle_us  <= RST_NIBBLE_SETTLE;
      cfg.command_settle_us <= RST_COMMAND_SETTLE;
      cfg.clear_wait_us     <= RST_CLEAR_WAIT;
      cfg.powerup_wait_us   <= RST_POWERUP_WAIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ENABLE_PULSE:   cfg.enable_pulse_us   <= cfg_data[7:0];
        CFG_NIBBLE_SETTLE:  cfg.nibble_settle_us  <= cfg_data[7:0];
        CFG_COMMAND_SETTLE: cfg.command_settle_us <= cfg_data[9:0];
        CFG_CLEAR_WAIT:     cfg.clear_wait_us     <= cfg_data[15:0];
        CFG_POWERUP_WAIT:   cfg.powerup_wait_us   <= cfg_data[17:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ sv/lcdns_front.sv @@
module lcdns_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic            operation,
  input  logic [7:0]      byte_value,
  input  logic            register_select,
  output logic            q_push,
  output lcdns_pkg::job_t q_job,
  input  logic            q_full
);
  import lcdns_pkg::*;

  logic fvalid;
  logic fvalid_next;
  logic accept;
  job_t job_in;

  // classify: initialise forces command register, clear wait only for command 0x01
  always_comb begin
    job_in.is_init    = (operation == OP_INIT);
    job_in.rs         = job_in.is_init ? 1'b0 : register_select;
    job_in.byte_value = byte_value;
    job_in.clear      = !job_in.is_init && !register_select && (byte_value == BYTE_CLEAR);
  end

  assign full        = fvalid && q_full;
  assign accept      = push && !full;
  assign q_push      = fvalid && !q_full;
  assign fvalid_next = accept || (fvalid && !q_push);

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else begin
      fvalid <= fvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_job <= job_in;
    end
  end

endmodule

@@ sv/lcdns_queue.sv @@
module lcdns_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lcdns_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output lcdns_pkg::job_t pop_job,
  output logic            empty
);
  import lcdns_pkg::*;

  job_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic [QAW:0]   count_next;

  assign full    = (count == (QAW+1)'(QDEPTH));
  assign empty   = (count == '0);
  assign pop_job = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (QAW+1)'(QDEPTH))
    else $error("queue count out of range");
`endif

endmodule

@@ sv/lcdns_back.sv @@
module lcdns_back (
  input  logic                         clk,
  input  logic                         rst,
  input  lcdns_pkg::cfg_t              cfg,
  input  logic                         q_empty,
  input  lcdns_pkg::job_t              q_job,
  output logic                         q_pop,
  input  logic                         pop,
  output logic                         empty,
  output logic                         rs_level,
  output logic [3:0]                   data_nibble,
  output logic                         enable_level,
  output logic [lcdns_pkg::HOLD_W-1:0] hold_us,
  output logic                         last_phase
);
  import lcdns_pkg::*;

  seq_state_t        state;
  seq_state_t        state_next;
  job_t              job;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] s3;
  logic              out_valid;
  logic              out_valid_next;
  logic              advance;
  logic              load;
  logic              last;
  logic [7:0]        rom_byte;
  logic [7:0]        cur_byte;
  logic              cur_clear;
  logic [1:0]        sub;
  logic [HOLD_W-1:0] settle_hold;
  logic [HOLD_W-1:0] byte_end_hold;
  logic              ph_rs;
  logic [3:0]        ph_nib;
  logic              ph_en;
  logic [HOLD_W-1:0] ph_hold;

  assign advance = !out_valid || pop;
  assign empty   = !out_valid;

  // phase decode
  always_comb begin
    s3        = step - STEP_W'(INIT_LEAD);
    rom_byte  = init_rom(s3[STEP_W-1:2]);
    cur_byte  = job.is_init ? rom_byte : job.byte_value;
    cur_clear = job.is_init ? (rom_byte == BYTE_CLEAR) : job.clear;
    sub       = job.is_init ? s3[1:0] : step[1:0];
    last      = job.is_init ? (step == STEP_W'(INIT_STEPS-1)) : (step == STEP_W'(BYTE_STEPS-1));
    settle_hold   = HOLD_W'(cfg.nibble_settle_us);
    byte_end_hold = settle_hold + HOLD_W'(cfg.command_settle_us)
                  + (cur_clear ? HOLD_W'(cfg.clear_wait_us) : '0);
    ph_rs   = job.rs;
    ph_nib  = sub[1] ? cur_byte[3:0] : cur_byte[7:4];
    ph_en   = !sub[0];
    if (ph_en) begin
      ph_hold = HOLD_W'(cfg.enable_pulse_us);
    end else if (sub == 2'd3) begin
      ph_hold = byte_end_hold;
    end else begin
      ph_hold = settle_hold;
    end
    if (job.is_init && step == STEP_W'(0)) begin
      ph_nib  = 4'h0;
      ph_en   = 1'b0;
      ph_hold = cfg.powerup_wait_us;
    end else if (job.is_init && step == STEP_W'(1)) begin
      ph_nib  = NIBBLE_WAKE;
      ph_en   = 1'b1;
      ph_hold = HOLD_W'(cfg.enable_pulse_us);
    end else if (job.is_init && step == STEP_W'(2)) begin
      ph_nib  = NIBBLE_WAKE;
      ph_en   = 1'b0;
      ph_hold = settle_hold;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          state_next = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (advance && last && q_empty) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    load  = 1'b0;
    case (state)
      ST_IDLE: q_pop = !q_empty;
      ST_BUSY: begin
        load  = advance;
        q_pop = advance && last && !q_empty;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_next = load || (out_valid && !pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (q_pop) begin
        step <= '0;
      end else if (load) begin
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_job;
    end
    if (load) begin
      rs_level     <= ph_rs;
      data_nibble  <= ph_nib;
      enable_level <= ph_en;
      hold_us      <= ph_hold;
      last_phase   <= last;
    end
  end

`ifndef SYNTHESIS
  a_last_enable_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_phase |-> !enable_level)
    else $error("final phase with enable high");
  a_write_steps: assert property (@(posedge clk) disable iff (rst)
    state == ST_BUSY && !job.is_init |-> step < STEP_W'(BYTE_STEPS))
    else $error("byte write step out of range");
  a_init_steps: assert property (@(posedge clk) disable iff (rst)
    state == ST_BUSY && job.is_init |-> step < STEP_W'(INIT_STEPS))
    else $error("initialise step out of range");
  a_pop_when_free: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("job taken from empty queue");
`endif

endmodule

@@ sv/char_lcd_nibble_write_sequencer.sv @@
// channel   handshake                 payload
// input     push / full               operation, byte_value, register_select
// result    pop / empty               rs_level, data_nibble, enable_level, hold_us, last_phase
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A byte write gives 4 phases, one per cycle while results are taken, and items run back to
// back, as the back-end sequencer emits one phase a cycle into its output register.
// Initialise gives 27 phases. An accepted item passes the front register and job queue to the
// sequencer; a two-entry job queue lets input be taken while phases are still being emitted.
// Reset clears all control state and loads the register reset values; no clearing pass.
// A stalled result holds the sequencer; the front fills the queue and then raises full.
module char_lcd_nibble_write_sequencer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic                             operation,
  input  logic [7:0]                       byte_value,
  input  logic                             register_select,
  input  logic                             pop,
  output logic                             empty,
  output logic                             rs_level,
  output logic [3:0]                       data_nibble,
  output logic                             enable_level,
  output logic [lcdns_pkg::HOLD_W-1:0]     hold_us,
  output logic                             last_phase,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lcdns_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcdns_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lcdns_pkg::*;

  cfg_t cfg;
  job_t f_job;
  job_t q_job;
  logic f_push;
  logic q_full;
  logic q_empty;
  logic q_pop;

  lcdns_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lcdns_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .operation       (operation),
    .byte_value      (byte_value),
    .register_select (register_select),
    .q_push          (f_push),
    .q_job           (f_job),
    .q_full          (q_full)
  );

  lcdns_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (f_push),
    .push_job (f_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (q_job),
    .empty    (q_empty)
  );

  lcdns_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_job        (q_job),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .rs_level     (rs_level),
    .data_nibble  (data_nibble),
    .enable_level (enable_level),
    .hold_us      (hold_us),
    .last_phase   (last_phase)
  );

endmodule

@@ tb/sv/tb.sv @@
module tb;
  import lcdns_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int REG_COUNT   = 5;
  localparam int IDX_TOP     = (1 << CFG_IDX_W) - 1;
  localparam int PULSE_MAX   = 255;
  localparam int SETTLE_MAX  = 255;
  localparam int CMD_MAX     = 1023;
  localparam int CLEAR_MAX   = 65535;
  localparam int POWERUP_MAX = 262143;

  localparam logic [7:0] INIT_SEQ [6] = '{8'h28, 8'h28, 8'h08, 8'h01, 8'h06, 8'h0E};

  typedef struct packed {
    logic              rs;
    logic [3:0]        nib;
    logic              en;
    logic [HOLD_W-1:0] hold;
    logic              last;
  } lcd_phase_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  logic                 operation = 1'b0;
  logic [7:0]           byte_value = 8'h00;
  logic                 register_select = 1'b0;
  logic                 pop = 1'b0;
  logic                 empty;
  logic                 rs_level;
  logic [3:0]           data_nibble;
  logic                 enable_level;
  logic [HOLD_W-1:0]    hold_us;
  logic                 last_phase;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [7:0]  en_pulse   = RST_ENABLE_PULSE;
  logic [7:0]  nib_settle = RST_NIBBLE_SETTLE;
  logic [9:0]  cmd_settle = RST_COMMAND_SETTLE;
  logic [15:0] clr_wait   = RST_CLEAR_WAIT;
  logic [17:0] pwr_wait   = RST_POWERUP_WAIT;

  lcd_phase_t expected_phases[$];
  lcd_phase_t want_phase;

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int rx_gap = 0;
  int rx_hold = 0;
  int errors = 0;
  int items_sent = 0;
  int init_items = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int full_stalls = 0;
  int cycle_count;

  char_lcd_nibble_write_sequencer i_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .operation(operation),
    .byte_value(byte_value),
    .register_select(register_select),
    .pop(pop),
    .empty(empty),
    .rs_level(rs_level),
    .data_nibble(data_nibble),
    .enable_level(enable_level),
    .hold_us(hold_us),
    .last_phase(last_phase),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  function automatic void add_phase(input logic rs, input logic [3:0] nib, input logic en,
                                    input int hold);
    lcd_phase_t p;
    p.rs   = rs;
    p.nib  = nib;
    p.en   = en;
    p.hold = hold[HOLD_W-1:0];
    p.last = 1'b0;
    expected_phases.push_back(p);
  endfunction

  function automatic void add_nibble(input logic rs, input logic [3:0] nib, input int extra);
    add_phase(rs, nib, 1'b1, int'(en_pulse));
    add_phase(rs, nib, 1'b0, int'(nib_settle) + extra);
  endfunction

  function automatic void add_byte(input logic rs, input logic [7:0] b);
    int extra;
    extra = int'(cmd_settle);
    if (!rs && b == BYTE_CLEAR)
      extra += int'(clr_wait);
    add_nibble(rs, b[7:4], 0);
    add_nibble(rs, b[3:0], extra);
  endfunction

  function automatic void plan_phases(input logic op, input logic [7:0] b, input logic rs);
    lcd_phase_t p;
    if (op == OP_WRITE) begin
      add_byte(rs, b);
    end else begin
      add_phase(1'b0, 4'h0, 1'b0, int'(pwr_wait));
      add_nibble(1'b0, NIBBLE_WAKE, 0);
      foreach (INIT_SEQ[i])
        add_byte(1'b0, INIT_SEQ[i]);
    end
    p = expected_phases.pop_back();
    p.last = 1'b1;
    expected_phases.push_back(p);
  endfunction

  function automatic int pick_value(input int maxv);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return maxv;
      default: return $urandom_range(0, maxv);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 50)
      $display("MISMATCH at result %0d: %s", results_seen, msg);
  endtask

  task automatic send_item(input logic op, input logic [7:0] b, input logic rs);
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation = op;
    byte_value = b;
    register_select = rs;
    push = 1'b1;
    do @(posedge clk); while (full);
    plan_phases(op, b, rs);
    items_sent++;
    if (op == OP_INIT)
      init_items++;
    @(negedge clk);
  endtask

  task automatic send_random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)
      send_item(OP_INIT, 8'($urandom), 1'($urandom));
    else if (r < 18)
      send_item(OP_WRITE, BYTE_CLEAR, 1'($urandom));
    else
      send_item(OP_WRITE, 8'($urandom), 1'($urandom));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ENABLE_PULSE:   en_pulse   = data[7:0];
      CFG_NIBBLE_SETTLE:  nib_settle = data[7:0];
      CFG_COMMAND_SETTLE: cmd_settle = data[9:0];
      CFG_CLEAR_WAIT:     clr_wait   = data[15:0];
      CFG_POWERUP_WAIT:   pwr_wait   = data[17:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all_regs(input logic [CFG_DATA_W-1:0] data);
    write_reg(CFG_ENABLE_PULSE, data);
    write_reg(CFG_NIBBLE_SETTLE, data);
    write_reg(CFG_COMMAND_SETTLE, data);
    write_reg(CFG_CLEAR_WAIT, data);
    write_reg(CFG_POWERUP_WAIT, data);
  endtask

  task automatic write_random_reg(input logic [CFG_IDX_W-1:0] idx, input int maxv);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom) & ~CFG_DATA_W'(maxv);
    write_reg(idx, CFG_DATA_W'(pick_value(maxv)) | junk);
  endtask

  task automatic drain();
    push = 1'b0;
    while (expected_phases.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_reset_defaults();
    send_item(OP_WRITE, BYTE_CLEAR, 1'b0);
    send_item(OP_WRITE, BYTE_CLEAR, 1'b1);
    send_item(OP_INIT, 8'hFF, 1'b1);
    send_item(OP_WRITE, 8'h00, 1'b0);
    drain();
  endtask

  task automatic test_byte_extremes();
    send_item(OP_WRITE, 8'hFF, 1'b1);
    send_item(OP_WRITE, 8'h00, 1'b1);
    send_item(OP_WRITE, 8'hFF, 1'b0);
    send_item(OP_WRITE, 8'hA5, 1'b0);
    send_item(OP_WRITE, 8'h5A, 1'b1);
    send_item(OP_WRITE, 8'h28, 1'b0);
    send_item(OP_INIT, 8'h00, 1'b0);
    drain();
  endtask

  task automatic test_register_extremes();
    write_all_regs('0);
    send_item(OP_WRITE, BYTE_CLEAR, 1'b0);
    send_item(OP_WRITE, 8'h7E, 1'b1);
    send_item(OP_INIT, 8'h55, 1'b0);
    drain();
    write_all_regs('1);
    send_item(OP_WRITE, BYTE_CLEAR, 1'b0);
    send_item(OP_WRITE, BYTE_CLEAR, 1'b1);
    send_item(OP_INIT, 8'hAA, 1'b1);
    send_item(OP_WRITE, 8'hC3, 1'b0);
    drain();
    for (int k = REG_COUNT; k <= IDX_TOP; k++)
      write_reg(k[CFG_IDX_W-1:0], CFG_DATA_W'($urandom));
    send_item(OP_WRITE, BYTE_CLEAR, 1'b0);
    send_item(OP_INIT, 8'h0F, 1'b1);
    drain();
  endtask

  task automatic test_full_stall();
    tx_idle = 1'b0;
    @(posedge clk);
    rx_hold = 250;
    @(negedge clk);
    repeat (24) send_random_item();
    drain();
    tx_idle = 1'b1;
  endtask

  task automatic test_pause_resume();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (10) send_random_item();
    drain();
    repeat (10) send_random_item();
    drain();
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 6; phase++) begin
      write_random_reg(CFG_ENABLE_PULSE, PULSE_MAX);
      write_random_reg(CFG_NIBBLE_SETTLE, SETTLE_MAX);
      write_random_reg(CFG_COMMAND_SETTLE, CMD_MAX);
      write_random_reg(CFG_CLEAR_WAIT, CLEAR_MAX);
      write_random_reg(CFG_POWERUP_WAIT, POWERUP_MAX);
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, IDX_TOP)), CFG_DATA_W'($urandom));
      if (phase == 0) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end else if (phase == 1) begin
        tx_idle = 1'b1;
        rx_idle = 1'b1;
      end else begin
        tx_idle = 1'($urandom);
        rx_idle = 1'($urandom);
      end
      repeat (65) send_random_item();
      drain();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  always @(negedge clk) begin
    if (rst) begin
      pop = 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      pop = 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      pop = 1'b0;
    end else begin
      pop = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && push && full)
      full_stalls++;
    if (!rst && pop && !empty) begin
      if (expected_phases.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want_phase = expected_phases.pop_front();
        if (rs_level !== want_phase.rs)
          report_mismatch($sformatf("rs_level %0h, expected %0h", rs_level, want_phase.rs));
        if (data_nibble !== want_phase.nib)
          report_mismatch($sformatf("data_nibble %0h, expected %0h", data_nibble,
                                    want_phase.nib));
        if (enable_level !== want_phase.en)
          report_mismatch($sformatf("enable_level %0h, expected %0h", enable_level,
                                    want_phase.en));
        if (hold_us !== want_phase.hold)
          report_mismatch($sformatf("hold_us %0d, expected %0d", hold_us, want_phase.hold));
        if (last_phase !== want_phase.last)
          report_mismatch($sformatf("last_phase %0h, expected %0h", last_phase,
                                    want_phase.last));
      end
      results_seen++;
      rx_gap = rx_idle ? $urandom_range(0, 15) : 0;
    end
  end

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
      @(posedge clk);
    $display("timeout after %0d cycles, %0d phases outstanding", CYCLE_LIMIT,
             expected_phases.size());
    $display("char_lcd_nibble_write_sequencer verification failed");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_defaults();
    test_byte_extremes();
    test_register_extremes();
    test_full_stall();
    test_pause_resume();
    test_random_phases();
    drain();
    $display("%0d items sent (%0d initialise), %0d phases checked, %0d register writes",
             items_sent, init_items, results_seen, reg_writes);
    $display("input held off by full for %0d cycles, %0d mismatches", full_stalls, errors);
    if (errors == 0 && expected_phases.size() == 0)
      $display("char_lcd_nibble_write_sequencer verification clean");
    else
      $display("char_lcd_nibble_write_sequencer verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
sv/lcdns_pkg.sv
sv/lcdns_cfg.sv
sv/lcdns_front.sv
sv/lcdns_queue.sv
sv/lcdns_back.sv
sv/char_lcd_nibble_write_sequencer.sv
tb/sv/tb.sv
